[hw/rtl/rgbe_rle_scanline_decoder_defines.svh]
// Assertion macros for the decoder files.
`ifndef RGBE_RLE_SCANLINE_DECODER_DEFINES_SVH
`define RGBE_RLE_SCANLINE_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is active.
`define RGBE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checked property, also evaluated during reset.
`define RGBE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RGBE_ASSERT(label, clk, rstn, prop, msg)
`define RGBE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[hw/rtl/rgbe_rle_pkg.sv]
package rgbe_rle_pkg;

    // Default store depth in pixels per plane
    localparam int MAX_WIDTH_DEF = 4096;

    // Store address field width (covers the largest supported depth)
    localparam int STORE_AW_MAX = 15;

    // Result status codes
    localparam logic [2:0] ST_PIXEL   = 3'd0;
    localparam logic [2:0] ST_BUSY    = 3'd1;
    localparam logic [2:0] ST_NOT_RLE = 3'd2;
    localparam logic [2:0] ST_WIDTH   = 3'd3;
    localparam logic [2:0] ST_RUN     = 3'd4;
    localparam logic [2:0] ST_LITERAL = 3'd5;

    // Register indexes
    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_LINE_COUNT = 1'b1;

    // One byte-lane write into the plane store
    typedef struct packed {
        logic                    en;
        logic [1:0]              lane;
        logic [STORE_AW_MAX-1:0] addr;
        logic [7:0]              data;
    } store_wr_t;

endpackage

[hw/rtl/rgbe_rle_store.sv]
module rgbe_rle_store #(
    parameter int MAX_WIDTH = rgbe_rle_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                    clk,
    input  rgbe_rle_pkg::store_wr_t wr,
    input  logic [AW-1:0]           rd_addr,
    output logic [31:0]             rd_data    // r, g, b, e from the lowest byte up
);

    // One word per column, one byte lane per plane
    logic [3:0][7:0] mem [MAX_WIDTH];

    // Byte-lane write, accesses beyond the depth are dropped
    always_ff @(posedge clk)
    begin
        if (wr.en && (16'(wr.addr) < 16'(MAX_WIDTH)))
        begin
            mem[wr.addr[AW-1:0]][wr.lane] <= wr.data;
        end
    end

    // Registered read of all four planes
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/rgbe_rle_conv.sv]
module rgbe_rle_conv (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] pix,          // r, g, b, e from the lowest byte up
    output logic [31:0] red_reg,
    output logic [31:0] green_reg,
    output logic [31:0] blue_reg
);

    // Exact single-precision bits of m * 2^(e-136), zero when e or m is zero
    function automatic logic [31:0] rgbe_bits(input logic [7:0] m, input logic [7:0] e);
        logic [2:0]         p;
        logic signed [10:0] ex;
        logic signed [10:0] bexp;
        logic [31:0]        mm;
        logic [31:0]        mant;
        logic [31:0]        res;
        p = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (m[i])
            begin
                p = 3'(i);
            end
        end
        ex   = $signed({8'b0, p}) + $signed({3'b0, e}) - 11'sd136;
        bexp = ex + 11'sd127;
        mm   = {24'b0, m};
        mant = mm << (5'd23 - 5'(p));
        if (e == 8'd0 || m == 8'd0)
        begin
            res = '0;
        end
        else if (ex >= -11'sd126)
        begin
            res = {1'b0, bexp[7:0], mant[22:0]};
        end
        else
        begin
            // subnormal result
            res = mm << (6'(e) + 6'd13);
        end
        return res;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= rgbe_bits(pix[7:0],   pix[31:24]);
            green_reg <= rgbe_bits(pix[15:8],  pix[31:24]);
            blue_reg  <= rgbe_bits(pix[23:16], pix[31:24]);
        end
    end

endmodule

[hw/rtl/rgbe_rle_scanline_decoder.sv]
// RGBE adaptive run-length scanline decoder.
// Input stream: s_tdata carries one pixel-data byte, s_tuser selects a data
// byte (0) or a tick that asks for the next decoded pixel (1).
// Output stream: one result per transfer; s_tuser-style status in m_tuser,
// float bits and position in m_tdata, m_tlast marks the last pixel of a line.
// Configuration: cfg_index 0 = line width, 1 = line count; write while idle.
// Timing: a header, count, value or literal byte is handled in the cycle it
// is accepted. A run value byte starts one store write per cycle for a run
// of up to 127. A tick passes through store read, float conversion and the
// output register to its result. Errors appear in the cycle after the byte.
// The single write/read port pair of the plane store sets this timing.
// Input is taken only while no result waits in the output register, or when
// that result is taken in the same cycle; a stalled receiver holds the block.
// Reset: decoder at the first header byte, counters cleared, width 8, count 1.
// The plane store is not cleared; every entry read is written first.
// An error status (2..5) stops the decoder until the next reset.
module rgbe_rle_scanline_decoder #(
    parameter int MAX_WIDTH = rgbe_rle_pkg::MAX_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,      // [7:0] data_byte
    input  logic [0:0]   s_tuser,      // [0] mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,      // red_bits, green_bits, blue_bits, pixel_x, line_y, pad
    output logic         m_tlast,      // last_in_line
    output logic [3:0]   m_tuser,      // [2:0] status, [3] last_of_image
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);

    `include "rgbe_rle_scanline_decoder_defines.svh"

    localparam int AW = $clog2(MAX_WIDTH);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_READ, S_CONV} state_t;
    typedef enum logic [2:0] {
        PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_COUNT, PH_VALUE, PH_LITERAL
    } phase_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [6:0]  hdr_hi_reg, hdr_hi_next;
    logic [1:0]  plane_reg, plane_next;
    logic [12:0] wpos_reg, wpos_next;
    logic [6:0]  lit_left_reg, lit_left_next;
    logic [6:0]  run_left_reg, run_left_next;
    logic [7:0]  run_val_reg, run_val_next;
    logic [12:0] epos_reg, epos_next;
    logic [15:0] ldec_reg, ldec_next;
    logic [15:0] lemit_reg, lemit_next;
    logic        stop_reg, stop_next;
    logic [12:0] lw_reg, lw_next;
    logic [15:0] lc_reg, lc_next;
    logic        oob_reg, oob_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic [31:0] out_red_reg, out_red_next;
    logic [31:0] out_green_reg, out_green_next;
    logic [31:0] out_blue_reg, out_blue_next;
    logic [12:0] out_x_reg, out_x_next;
    logic [15:0] out_y_reg, out_y_next;
    logic        out_ll_reg, out_ll_next;
    logic        out_li_reg, out_li_next;
    logic [12:0] meta_x_reg, meta_x_next;
    logic [15:0] meta_y_reg, meta_y_next;
    logic        meta_ll_reg, meta_ll_next;
    logic        meta_li_reg, meta_li_next;

    rgbe_rle_pkg::store_wr_t wr;
    logic [15:0]  rd_addr_ext;
    logic [31:0]  rd_data;
    logic         conv_en;
    logic [31:0]  conv_pix;
    logic [31:0]  conv_red, conv_green, conv_blue;
    logic         acc;
    logic         end_chk;
    logic [13:0]  room;
    logic [13:0]  wp_inc;
    logic         last_line;
    logic         last_img;
    logic [14:0]  hdr_w;
    logic [6:0]   run_n;
    logic [15:0]  x_ext;

    rgbe_rle_store #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr_ext[AW-1:0]),
        .rd_data (rd_data)
    );

    rgbe_rle_conv u_conv (
        .clk       (clk),
        .en        (conv_en),
        .pix       (conv_pix),
        .red_reg   (conv_red),
        .green_reg (conv_green),
        .blue_reg  (conv_blue)
    );

    // Handshakes
    assign s_tready    = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign cfg_ready   = 1'b1;
    assign acc         = s_tvalid && s_tready;
    assign rd_addr_ext = 16'(epos_reg);
    assign conv_pix    = oob_reg ? 32'd0 : rd_data;

    // Derived values
    assign room      = (14'(wpos_reg) < 14'(lw_reg)) ? (14'(lw_reg) - 14'(wpos_reg)) : 14'd0;
    assign wp_inc    = 14'(wpos_reg) + 14'd1;
    assign last_line = (14'(epos_reg) + 14'd1) >= 14'(lw_reg);
    assign last_img  = last_line && ((17'(lemit_reg) + 17'd1) >= 17'(lc_reg));
    assign hdr_w     = {hdr_hi_reg, s_tdata};
    assign run_n     = s_tdata[6:0];

    // Output ports
    assign x_ext    = 16'(out_x_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_y_reg, x_ext[11:0], out_blue_reg, out_green_reg, out_red_reg};
    assign m_tlast  = out_ll_reg;
    assign m_tuser  = {out_li_reg, out_status_reg};

    // Decoder next state
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        hdr_hi_next     = hdr_hi_reg;
        plane_next      = plane_reg;
        wpos_next       = wpos_reg;
        lit_left_next   = lit_left_reg;
        run_left_next   = run_left_reg;
        run_val_next    = run_val_reg;
        epos_next       = epos_reg;
        ldec_next       = ldec_reg;
        lemit_next      = lemit_reg;
        stop_next       = stop_reg;
        lw_next         = lw_reg;
        lc_next         = lc_reg;
        oob_next        = oob_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_red_next    = out_red_reg;
        out_green_next  = out_green_reg;
        out_blue_next   = out_blue_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_ll_next     = out_ll_reg;
        out_li_next     = out_li_reg;
        meta_x_next     = meta_x_reg;
        meta_y_next     = meta_y_reg;
        meta_ll_next    = meta_ll_reg;
        meta_li_next    = meta_li_reg;
        wr              = '0;
        wr.lane         = plane_reg;
        wr.addr         = 15'(wpos_reg);
        wr.data         = s_tdata;
        conv_en         = 1'b0;
        end_chk         = 1'b0;

        // configuration writes
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rgbe_rle_pkg::REG_LINE_WIDTH: lw_next = cfg_data[12:0];
                rgbe_rle_pkg::REG_LINE_COUNT: lc_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc && !stop_reg)
                begin
                    out_status_next = rgbe_rle_pkg::ST_PIXEL;
                    if (s_tuser[0])
                    begin
                        // tick: start a store read for the next pixel if a decoded line waits
                        if (lemit_reg < ldec_reg)
                        begin
                            meta_x_next  = epos_reg;
                            meta_y_next  = lemit_reg;
                            meta_ll_next = last_line;
                            meta_li_next = last_img;
                            oob_next     = 16'(epos_reg) >= 16'(MAX_WIDTH);
                            if (last_line)
                            begin
                                epos_next  = '0;
                                lemit_next = lemit_reg + 16'd1;
                            end
                            else
                            begin
                                epos_next = epos_reg + 13'd1;
                            end
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_HDR0:
                            begin
                                if (ldec_reg >= lc_reg)
                                begin
                                end
                                else if (lemit_reg < ldec_reg)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = rgbe_rle_pkg::ST_BUSY;
                                end
                                else if (s_tdata != 8'd2)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = rgbe_rle_pkg::ST_NOT_RLE;
                                end
                                else
                                begin
                                    phase_next = PH_HDR1;
                                end
                            end
                            PH_HDR1:
                            begin
                                if (s_tdata != 8'd2)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = rgbe_rle_pkg::ST_NOT_RLE;
                                end
                                else
                                begin
                                    phase_next = PH_HDR2;
                                end
                            end
                            PH_HDR2:
                            begin
                                if (s_tdata[7])
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = rgbe_rle_pkg::ST_NOT_RLE;
                                end
                                else
                                begin
                                    hdr_hi_next = s_tdata[6:0];
                                    phase_next  = PH_HDR3;
                                end
                            end
                            PH_HDR3:
                            begin
                                if ((16'(hdr_w) != 16'(lw_reg)) || (lw_reg < 13'd8) ||
                                    (16'(lw_reg) > 16'(MAX_WIDTH)))
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = rgbe_rle_pkg::ST_WIDTH;
                                end
                                else
                                begin
                                    plane_next = '0;
                                    wpos_next  = '0;
                                    phase_next = PH_COUNT;
                                end
                            end
                            PH_COUNT:
                            begin
                                if (s_tdata > 8'd128)
                                begin
                                    if (14'(run_n) > room)
                                    begin
                                        out_valid_next  = 1'b1;
                                        out_status_next = rgbe_rle_pkg::ST_RUN;
                                    end
                                    else
                                    begin
                                        run_left_next = run_n;
                                        lit_left_next = '0;
                                        phase_next    = PH_VALUE;
                                    end
                                end
                                else if ((s_tdata == 8'd0) || (14'(s_tdata) > room))
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = rgbe_rle_pkg::ST_LITERAL;
                                end
                                else
                                begin
                                    run_left_next = '0;
                                    lit_left_next = 7'(s_tdata - 8'd1);
                                    phase_next    = PH_VALUE;
                                end
                            end
                            PH_VALUE:
                            begin
                                if (run_left_reg != 7'd0)
                                begin
                                    run_val_next = s_tdata;
                                    state_next   = S_RUN;
                                end
                                else
                                begin
                                    wr.en     = 1'b1;
                                    wpos_next = wp_inc[12:0];
                                    if (lit_left_reg != 7'd0)
                                    begin
                                        phase_next = PH_LITERAL;
                                    end
                                    else
                                    begin
                                        end_chk = 1'b1;
                                    end
                                end
                            end
                            PH_LITERAL:
                            begin
                                wr.en     = 1'b1;
                                wpos_next = wp_inc[12:0];
                                if (lit_left_reg != 7'd0)
                                begin
                                    lit_left_next = lit_left_reg - 7'd1;
                                end
                                if (lit_left_reg <= 7'd1)
                                begin
                                    end_chk = 1'b1;
                                end
                            end
                            default: phase_next = PH_HDR0;
                        endcase
                        // errors clear the payload; all but busy stop the decoder
                        if (out_status_next != rgbe_rle_pkg::ST_PIXEL)
                        begin
                            out_red_next   = '0;
                            out_green_next = '0;
                            out_blue_next  = '0;
                            out_x_next     = '0;
                            out_y_next     = '0;
                            out_ll_next    = 1'b0;
                            out_li_next    = 1'b0;
                            if (out_status_next != rgbe_rle_pkg::ST_BUSY)
                            begin
                                stop_next = 1'b1;
                            end
                        end
                    end
                end
            end
            S_RUN:
            begin
                // one store write per cycle for a run
                wr.en         = 1'b1;
                wr.data       = run_val_reg;
                wpos_next     = wp_inc[12:0];
                run_left_next = run_left_reg - 7'd1;
                if (run_left_reg == 7'd1)
                begin
                    end_chk    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                conv_en    = 1'b1;
                state_next = S_CONV;
            end
            S_CONV:
            begin
                out_valid_next  = 1'b1;
                out_status_next = rgbe_rle_pkg::ST_PIXEL;
                out_red_next    = conv_red;
                out_green_next  = conv_green;
                out_blue_next   = conv_blue;
                out_x_next      = meta_x_reg;
                out_y_next      = meta_y_reg;
                out_ll_next     = meta_ll_reg;
                out_li_next     = meta_li_reg;
                state_next      = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        // plane and line end check after the last write of each run or literal
        if (end_chk)
        begin
            if (wp_inc < 14'(lw_reg))
            begin
                phase_next = PH_COUNT;
            end
            else
            begin
                wpos_next = '0;
                if (plane_reg == 2'd3)
                begin
                    plane_next = '0;
                    ldec_next  = ldec_reg + 16'd1;
                    phase_next = PH_HDR0;
                end
                else
                begin
                    plane_next = plane_reg + 2'd1;
                    phase_next = PH_COUNT;
                end
            end
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_HDR0;
            hdr_hi_reg     <= '0;
            plane_reg      <= '0;
            wpos_reg       <= '0;
            lit_left_reg   <= '0;
            run_left_reg   <= '0;
            run_val_reg    <= '0;
            epos_reg       <= '0;
            ldec_reg       <= '0;
            lemit_reg      <= '0;
            stop_reg       <= 1'b0;
            lw_reg         <= 13'd8;
            lc_reg         <= 16'd1;
            oob_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= rgbe_rle_pkg::ST_PIXEL;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            hdr_hi_reg     <= hdr_hi_next;
            plane_reg      <= plane_next;
            wpos_reg       <= wpos_next;
            lit_left_reg   <= lit_left_next;
            run_left_reg   <= run_left_next;
            run_val_reg    <= run_val_next;
            epos_reg       <= epos_next;
            ldec_reg       <= ldec_next;
            lemit_reg      <= lemit_next;
            stop_reg       <= stop_next;
            lw_reg         <= lw_next;
            lc_reg         <= lc_next;
            oob_reg        <= oob_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_red_reg   <= out_red_next;
        out_green_reg <= out_green_next;
        out_blue_reg  <= out_blue_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_ll_reg    <= out_ll_next;
        out_li_reg    <= out_li_next;
        meta_x_reg    <= meta_x_next;
        meta_y_reg    <= meta_y_next;
        meta_ll_reg   <= meta_ll_next;
        meta_li_reg   <= meta_li_next;
    end

    // Checks
    `RGBE_ASSERT(a_in_only_when_out_free, clk, rst_n, (s_tvalid && s_tready) |-> (!out_valid_reg || m_tready), "input transfer while result waits")
    `RGBE_ASSERT(a_conv_lands_free, clk, rst_n, (state_reg == S_CONV) |-> !out_valid_reg, "pixel result would overwrite pending result")
    `RGBE_ASSERT(a_stop_sticky, clk, rst_n, stop_reg |=> stop_reg, "stop flag cleared without reset")
    `RGBE_ASSERT(a_stop_reports, clk, rst_n, $rose(stop_reg) |-> (out_valid_reg && (out_status_reg != rgbe_rle_pkg::ST_PIXEL) && (out_status_reg != rgbe_rle_pkg::ST_BUSY)), "stop without error result")
    `RGBE_ASSERT(a_run_nonzero, clk, rst_n, (state_reg == S_RUN) |-> (run_left_reg != 7'd0), "run state with no writes left")

endmodule
